// File: rtl/http_chunked_body_decoder_defines.svh
// assertion macros shared by the chunked body decoder rtl
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HCBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hcbd_pkg.sv
// shared types, constants and helpers for the chunked body decoder
`default_nettype none

package hcbd_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int SIZE_W_MAX      = 32;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    typedef enum logic [5:0] {
        PH_SIZE = 6'b000001,
        PH_SKIP = 6'b000010,
        PH_SLF  = 6'b000100,
        PH_DATA = 6'b001000,
        PH_TCR  = 6'b010000,
        PH_TLF  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_result;

    typedef struct packed {
        t_phase phase;
        logic   rem_zero;
    } t_status;

    // bit 4 set when the byte is a hex digit, low nibble is its value
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'b0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hcbd_in_reg.sv
// input register stage holding one body word
`default_nettype none

module hcbd_in_reg (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  wire  [7:0] i_byte,
    input  wire        i_eob,
    input  wire        i_adv,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_eob
);
    import hcbd_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_eob;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_eob   = r_eob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
            r_eob  <= i_eob;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hcbd_parse.sv
// chunk framing state and per-word decode
`default_nettype none

module hcbd_parse #(
    parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_adv,
    input  wire  [7:0]        i_byte,
    input  wire               i_eob,
    output hcbd_pkg::t_result o_res,
    output hcbd_pkg::t_status o_status
);
    import hcbd_pkg::*;

    localparam int RW = (LENGTH_BITS < SIZE_W_MAX) ? LENGTH_BITS : SIZE_W_MAX;

    t_phase        r_phase, n_phase;
    logic [RW-1:0] r_rem, n_rem;
    t_phase        eff;
    logic [RW-1:0] rem_eff;
    logic [RW-1:0] rem_dec;
    logic [RW+3:0] acc;
    logic [4:0]    hex;
    logic          done;

    assign hex     = hex_digit(i_byte);
    assign acc     = {rem_eff, hex[3:0]};
    assign rem_dec = rem_eff - RW'(1);

    always_comb begin
        eff     = r_phase;
        rem_eff = r_rem;
        n_phase = r_phase;
        n_rem   = r_rem;
        done    = 1'b0;
        o_res   = '{valid: 1'b0, data: i_byte, last: 1'b0};

        // resolve the phase that finally takes this word
        case (r_phase)
            PH_SIZE, PH_SKIP, PH_DATA, PH_TCR, PH_TLF: begin
            end
            PH_SLF: begin
                eff = (r_rem != '0) ? PH_DATA : PH_TCR;
                if (i_byte == BYTE_LF) begin
                    n_phase = eff;
                    done    = 1'b1;
                end
            end
            default: begin
                eff     = PH_SIZE;
                rem_eff = '0;
            end
        endcase

        if (!done) begin
            if ((eff == PH_TCR && i_byte != BYTE_CR) ||
                (eff == PH_TLF && i_byte != BYTE_LF)) begin
                eff     = PH_SIZE;
                rem_eff = '0;
            end
            n_phase = eff;
            n_rem   = rem_eff;
            case (eff)
                PH_SIZE: begin
                    if (hex[4]) begin
                        // saturate when the shifted size no longer fits
                        n_rem = (acc[RW+3:RW] != 4'b0) ? '1 : acc[RW-1:0];
                    end else if (i_byte == BYTE_CR) begin
                        n_phase = PH_SLF;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (i_byte == BYTE_CR) begin
                        n_phase = PH_SLF;
                    end
                end
                PH_DATA: begin
                    n_rem       = rem_dec;
                    o_res.valid = 1'b1;
                    o_res.last  = (rem_dec == '0);
                    if (rem_dec == '0) begin
                        n_phase = PH_TCR;
                    end
                end
                PH_TCR: begin
                    n_phase = PH_TLF;
                end
                PH_TLF: begin
                    n_phase = PH_SIZE;
                    n_rem   = '0;
                end
                default: begin
                    n_phase = PH_SIZE;
                    n_rem   = '0;
                end
            endcase
        end

        if (i_eob) begin
            n_phase = PH_SIZE;
            n_rem   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_rem   <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
        end
    end

    assign o_status = '{phase: r_phase, rem_zero: (r_rem == '0)};

endmodule

`default_nettype wire

// File: rtl/hcbd_out_reg.sv
// result register for decoded payload words
`default_nettype none

module hcbd_out_reg (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,
    input  hcbd_pkg::t_result i_res,
    input  wire               i_ready,
    output logic              o_valid,
    output logic [7:0]        o_data,
    output logic              o_last
);
    import hcbd_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_res.data;
            r_last <= i_res.last;
        end
    end

endmodule

`default_nettype wire

// File: rtl/http_chunked_body_decoder.sv
// chunked transfer body decoder: strips size lines and trailers, passes payload
// input channel: one body word per handshake (i_in_valid / o_in_ready) with an
//   end-of-body flag; the flagged word is decoded and the framing then restarts
//   at the size digits
// output channel: one payload word per handshake (o_out_valid / i_out_ready)
//   with chunk_last marking the final word of each chunk; size lines, the
//   optional line ends and skipped text give no output word
// path: a taken input word is held in the input register, decoded, and its
//   payload word is presented from the result register (input register, then result register)
// throughput: 1 word per cycle while the output is not stalled; the phase and
//   size counter update in the single decode step between the two registers
// stall: while the result register is full and not taken, the decode step
//   holds and the input register keeps one word; o_in_ready drops only when
//   both are occupied
// reset: synchronous, active low; both registers empty, framing back at the
//   size digits with a zero size
`default_nettype none

module http_chunked_body_decoder #(
    parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire  [7:0] i_body_byte,
    input  wire        i_end_of_body,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_chunk_last
);
    import hcbd_pkg::*;
    `include "http_chunked_body_decoder_defines.svh"

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_eob;
    logic       adv;
    t_result    res;
    t_status    status;

    // a stored word moves on when the result register can take whatever it yields
    assign adv = in_valid && (!o_out_valid || i_out_ready);

    hcbd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_body_byte),
        .i_eob   (i_end_of_body),
        .i_adv   (adv),
        .o_ready (o_in_ready),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .o_eob   (in_eob)
    );

    hcbd_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_byte   (in_byte),
        .i_eob    (in_eob),
        .o_res    (res),
        .o_status (status)
    );

    hcbd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && res.valid),
        .i_res   (res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_payload_byte),
        .o_last  (o_chunk_last)
    );

    `HCBD_ASSERT_NOW(a_data_rem_nonzero, i_clk, i_rst_n,
        status.phase == PH_DATA, !status.rem_zero,
        "payload phase entered with no bytes due")
    `HCBD_ASSERT_NEXT(a_last_ends_chunk, i_clk, i_rst_n,
        adv && res.valid && res.last && !in_eob, status.phase == PH_TCR,
        "last payload word did not move to trailer")
    `HCBD_ASSERT_NOW(a_backpressure_only, i_clk, i_rst_n,
        !o_in_ready, o_out_valid && !i_out_ready && in_valid,
        "input stalled without a held result")

endmodule

`default_nettype wire
